### design/wsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsc_pkg;

  localparam int EmaShift = 3;
  localparam int CordicSteps = 16;
  localparam int AccW = 52;
  localparam int InvGainQ16 = 39797;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        heading;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic               obstructed;
    logic               new_target;
  } wsc_in_t;

  typedef struct packed {
    logic [11:0]        speed;
    logic signed [15:0] turn_rate;
    logic               at_waypoint;
  } wsc_out_t;

  typedef enum logic [2:0] {
    CfgDistanceGain = 3'd0,
    CfgMaxSpeed     = 3'd1,
    CfgAngleGain    = 3'd2,
    CfgMaxTurn      = 3'd3,
    CfgArriveDist   = 3'd4,
    CfgSlowDist     = 3'd5,
    CfgDeadband     = 3'd6,
    CfgSlowAngle    = 3'd7
  } cfg_idx_t;

  function automatic logic [31:0] atan_q32(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
        5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
        5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### design/waypoint_steering_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Proportional waypoint steering controller. One result item follows every input item.
// The CORDIC is a preload and 16 iterations of a shared add/shift unit. A shift-and-add
// multiplier takes one multiplier bit per cycle for the distance scaling, the speed
// gain (the filter update shares its first cycle) and the turn gain. A restoring
// divider gives one quotient bit per cycle, with a finishing step to collect the
// quotient: 29 bits for the slow-zone ratio and 17 for a tenth or for three tenths.
// Inside the slow zone one division runs, and above the slow angle a second one. The
// block works on one item at a time. A finished result sits in the output register
// while the next item is accepted and worked on; if that result is still waiting when
// the next one is ready, the block stalls in its last step. The next item can be
// accepted in the cycle after the result is written. Configuration writes land at once
// and must only happen while the block is idle. Speed is in mm/s, turn rate in 2^-10
// rad/s, angles in binary-angle units.
module waypoint_steering_controller (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wsc_pkg::wsc_in_t      in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output wsc_pkg::wsc_out_t     out_data,
  input  wire                   cfg_we,
  input  wire  [2:0]            cfg_index,
  input  wire  [15:0]           cfg_data
);
  import wsc_pkg::*;

  // Sequencer states.
  typedef enum logic [10:0] {
    SIdle   = 11'b00000000001,
    SCord   = 11'b00000000010,
    SDist   = 11'b00000000100,
    SFilt   = 11'b00000001000,
    SSpd    = 11'b00000010000,
    STurn   = 11'b00000100000,
    SSlow   = 11'b00001000000,
    SAng    = 11'b00010000000,
    SDiv    = 11'b00100000000,
    SFinish = 11'b01000000000,
    SOut    = 11'b10000000000
  } state_t;

  state_t state;

  logic [15:0] distance_gain, angle_gain, arrive_distance, slow_distance;
  logic [11:0] speed_limit;
  logic [14:0] max_turn, angle_deadband, slow_angle;
  logic signed [23:0] filtered_error;

  wsc_in_t item;
  logic signed [AccW-1:0] cx, cy;
  logic [31:0] cz;
  logic [4:0]  step;
  logic [5:0]  cnt;
  logic [25:0] range_mm;
  logic signed [16:0] err;
  logic signed [23:0] fval;
  logic [23:0] absf;
  logic [31:0] spd;
  logic signed [16:0] turn;
  logic        zero_vec;

  // Serial multiplier: product += mcand when multiplier bit is set.
  logic [63:0] mprod;
  logic [35:0] mplier;
  logic [63:0] mcand;

  // Serial divider.
  logic [33:0] dnum;
  logic [16:0] dden;
  logic [16:0] drem;
  logic [1:0]  div_phase; // which division stage runs
  localparam logic [1:0] DivRatio = 2'd0, DivTenth = 2'd1, DivThree = 2'd2;

  logic signed [25:0] dxw, dyw;
  logic signed [AccW-1:0] sx, sy;
  logic [15:0] bearing;
  logic [15:0] diff_e;
  logic [17:0] rem_try;
  logic [63:0] turn_mag;

  always_comb begin
    dxw = 26'(item.target_x) - 26'(item.pos_x);
    dyw = 26'(item.target_y) - 26'(item.pos_y);
    sx = cx >>> step;
    sy = cy >>> step;
    rem_try = {drem, dnum[33]} - {1'b0, dden};
    bearing = zero_vec ? 16'd0 : 16'((cz + 32'h8000) >> 16);
    diff_e = bearing - item.heading;
    // Magnitude of the rounded turn; a negative error rounds its magnitude half down.
    turn_mag = fval[23] ? ((mprod + 64'h7FFF) >> 16) : ((mprod + 64'h8000) >> 16);
  end

  assign in_ready = (state == SIdle);

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_gain <= 16'd256; speed_limit <= 12'd500; angle_gain <= 16'd512;
      max_turn <= 15'd2048; arrive_distance <= 16'd200; slow_distance <= 16'd800;
      angle_deadband <= 15'd1037; slow_angle <= 15'd8192;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgDistanceGain: distance_gain <= cfg_data;
        CfgMaxSpeed:     speed_limit <= cfg_data[11:0];
        CfgAngleGain:    angle_gain <= cfg_data;
        CfgMaxTurn:      max_turn <= cfg_data[14:0];
        CfgArriveDist:   arrive_distance <= cfg_data;
        CfgSlowDist:     slow_distance <= cfg_data;
        CfgDeadband:     angle_deadband <= cfg_data[14:0];
        CfgSlowAngle:    slow_angle <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
      filtered_error <= '0;
    end else begin
      if (out_valid && out_ready && state != SOut) out_valid <= 1'b0;
      unique case (state)
        SIdle: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            state <= SCord;
            // Step 31 marks the preload cycle.
            step <= 5'd31;
            cz <= '0;
            zero_vec <= 1'b0;
          end
        end
        SCord: begin
          if (step == 5'd31) begin
            // Preload the vector, folding the left half plane by a half turn.
            zero_vec <= (dxw == 26'sd0) && (dyw == 26'sd0);
            if (dxw < 0) begin
              cx <= -(AccW'(dxw) <<< 8);
              cy <= -(AccW'(dyw) <<< 8);
              cz <= 32'h80000000;
            end else begin
              cx <= AccW'(dxw) <<< 8;
              cy <= AccW'(dyw) <<< 8;
              cz <= 32'h0;
            end
            step <= 5'd0;
          end else begin
            if (cy >= 0) begin
              cx <= cx + sy; cy <= cy - sx; cz <= cz + atan_q32(step);
            end else begin
              cx <= cx - sy; cy <= cy + sx; cz <= cz - atan_q32(step);
            end
            if (step == 5'(CordicSteps - 1)) begin
              state <= SDist;
              mprod <= '0;
              mcand <= 64'(InvGainQ16);
              cnt <= '0;
            end else begin
              step <= step + 5'd1;
            end
            if (step == 5'd0) mplier <= '0;
          end
        end
        SDist: begin
          // x * 39797, one multiplier bit per cycle.
          if (cnt == 6'd0) mplier <= cx[35:0] & {36{~cx[AccW-1]}};
          else begin
            if (mplier[0]) mprod <= mprod + mcand;
            mplier <= mplier >> 1;
            mcand <= mcand << 1;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd36) begin
            state <= SFilt;
          end
        end
        SFilt: begin
          range_mm <= zero_vec ? 26'd0 : 26'((mprod + 64'h800000) >> 24);
          err <= {diff_e[15], diff_e};
          fval <= item.new_target ? 24'sd0 : filtered_error;
          state <= SSpd;
          cnt <= '0;
        end
        SSpd: begin
          if (cnt == 6'd0) begin
            // Filter update, then start gain * distance.
            fval <= fval + 24'((25'(err) * 25'sd256 - 25'(fval)) >>> EmaShift);
            mprod <= '0;
            mcand <= 64'(distance_gain);
            mplier <= 36'(range_mm);
          end else begin
            if (mplier[0]) mprod <= mprod + mcand;
            mplier <= mplier >> 1;
            mcand <= mcand << 1;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd27) begin
            filtered_error <= fval;
            absf <= fval[23] ? 24'(-fval) : fval;
            state <= STurn;
            cnt <= '0;
          end
        end
        STurn: begin
          if (cnt == 6'd0) begin
            spd <= ((mprod >> 8) > 64'(speed_limit)) ? 32'(speed_limit) : 32'(mprod >> 8);
            mprod <= '0;
            mcand <= 64'(angle_gain);
            mplier <= 36'(absf);
          end else begin
            if (mplier[0]) mprod <= mprod + mcand;
            mplier <= mplier >> 1;
            mcand <= mcand << 1;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd24) state <= SSlow;
        end
        SSlow: begin
          // Signed rounding: floor((g*f + 2^15) / 2^16) via magnitude, clamped at full width.
          if (absf < {angle_deadband, 8'd0}) turn <= '0;
          else if (turn_mag > 64'(max_turn)) turn <= fval[23] ? -17'(max_turn) : 17'(max_turn);
          else turn <= fval[23] ? -17'(turn_mag) : 17'(turn_mag);
          if (range_mm < 26'(slow_distance)) begin
            if ((slow_distance <= arrive_distance) || (range_mm <= 26'(arrive_distance)) ||
                (5'd10 * 21'(range_mm - 26'(arrive_distance)) <
                 21'(slow_distance - arrive_distance))) begin
              dnum <= {spd[16:0], 17'd0}; dden <= 17'd10; div_phase <= DivTenth;
            end else begin
              // spd * n fits in 29 bits; it is formed by a small multiply.
              dnum <= {34'(spd * 32'(range_mm - 26'(arrive_distance)))} << 5;
              dden <= 17'(slow_distance - arrive_distance);
              div_phase <= DivRatio;
            end
            drem <= '0; cnt <= '0;
            state <= SDiv;
          end else state <= SAng;
        end
        SDiv: begin
          drem <= rem_try[17] ? {drem[15:0], dnum[33]} : rem_try[16:0];
          dnum <= {dnum[32:0], ~rem_try[17]};
          cnt <= cnt + 6'd1;
          if ((div_phase == DivRatio && cnt == 6'd28) ||
              (div_phase != DivRatio && cnt == 6'd16)) state <= SFinish;
        end
        SFinish: begin
          spd <= (div_phase == DivRatio) ? 32'(dnum[28:0]) : 32'(dnum[16:0]);
          state <= (div_phase == DivThree) ? SOut : SAng;
        end
        SAng: begin
          if (absf > {slow_angle, 8'd0}) begin
            dnum <= {34'(spd * 32'd3)} << 17; dden <= 17'd10;
            div_phase <= DivThree; drem <= '0; cnt <= '0;
            state <= SDiv;
          end else state <= SOut;
        end
        SOut: begin
          if (!out_valid || out_ready) begin
            out_data.speed <= item.obstructed ? 12'd0 : spd[11:0];
            out_data.turn_rate <= item.obstructed ?
              (err > 0 ? 16'(max_turn) : -16'(max_turn)) : turn[15:0];
            out_data.at_waypoint <= range_mm < 26'(arrive_distance);
            out_valid <= 1'b1;
            state <= SIdle;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == SIdle) else $error("ready outside idle");
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state code");
  a_turn_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.turn_rate[15] |-> out_data.turn_rate <= 16'(max_turn))
    else $error("turn clamp");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == SCord) else $error("no start");
`endif

endmodule
`default_nettype wire

### tb/waypoint_steering_controller_checker.sv
`timescale 1ns / 1ps
// Follows both channels and the register port, works out the command that each
// accepted pose should produce, and compares every result with it in order.
module waypoint_steering_controller_checker (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  wsc_pkg::wsc_in_t     in_data,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  wsc_pkg::wsc_out_t    out_data,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_index,
  input  wire  [15:0]          cfg_data,
  output int                   mismatches,
  output int                   pending,
  output int                   results_seen
);
  import wsc_pkg::*;

  localparam logic [31:0] ARC_TAB [0:15] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  longint dist_gain, speed_cap, turn_gain, turn_cap;
  longint arrive_mm, slow_mm, dead_band, slow_err;
  longint err_avg;
  wsc_out_t cmd_queue[$];

  function automatic wsc_out_t steer_command(wsc_in_t p);
    longint dx, dy, x, y, nx, ny, range_mm, f, absf, spd, turn, n, d;
    logic [31:0] z, zr;
    logic [15:0] brg, wrapped;
    int err;
    wsc_out_t r;
    dx = longint'($signed(p.target_x)) - longint'($signed(p.pos_x));
    dy = longint'($signed(p.target_y)) - longint'($signed(p.pos_y));
    if (dx == 0 && dy == 0) begin
      range_mm = 0;
      brg = 16'd0;
    end else begin
      x = dx * 256;
      y = dy * 256;
      z = 32'd0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z = z + ARC_TAB[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z = z - ARC_TAB[i];
        end
        x = nx;
        y = ny;
      end
      if (x < 0) x = 0;
      range_mm = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
      zr = z + 32'h8000;
      brg = zr[31:16];
    end
    wrapped = brg - p.heading;
    err = int'($signed(wrapped));
    if (p.new_target) err_avg = 0;
    f = err_avg + ((longint'(err) * 256 - err_avg) >>> EmaShift);
    err_avg = f;
    absf = (f < 0) ? -f : f;
    spd = (dist_gain * range_mm) >>> 8;
    if (spd > speed_cap) spd = speed_cap;
    if (absf < dead_band * 256) turn = 0;
    else turn = (turn_gain * f + 32768) >>> 16;
    if (range_mm < slow_mm) begin
      n = range_mm - arrive_mm;
      d = slow_mm - arrive_mm;
      if (d <= 0 || n <= 0 || 10 * n < d) spd = spd / 10;
      else spd = spd * n / d;
    end
    if (turn > turn_cap) turn = turn_cap;
    if (turn < -turn_cap) turn = -turn_cap;
    if (absf > slow_err * 256) spd = spd * 3 / 10;
    if (p.obstructed) begin
      spd = 0;
      turn = (err > 0) ? turn_cap : -turn_cap;
    end
    r.speed = spd[11:0];
    r.turn_rate = turn[15:0];
    r.at_waypoint = (range_mm < arrive_mm);
    return r;
  endfunction

  always @(posedge clk) begin
    wsc_out_t exp_cmd;
    int errs;
    errs = 0;
    if (rst) begin
      dist_gain <= 256; speed_cap <= 500; turn_gain <= 512; turn_cap <= 2048;
      arrive_mm <= 200; slow_mm <= 800; dead_band <= 1037; slow_err <= 8192;
      err_avg = 0;
      cmd_queue.delete();
      mismatches <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CfgDistanceGain: dist_gain <= longint'(cfg_data);
          CfgMaxSpeed:     speed_cap <= longint'(cfg_data[11:0]);
          CfgAngleGain:    turn_gain <= longint'(cfg_data);
          CfgMaxTurn:      turn_cap  <= longint'(cfg_data[14:0]);
          CfgArriveDist:   arrive_mm <= longint'(cfg_data);
          CfgSlowDist:     slow_mm   <= longint'(cfg_data);
          CfgDeadband:     dead_band <= longint'(cfg_data[14:0]);
          CfgSlowAngle:    slow_err  <= longint'(cfg_data[14:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) cmd_queue.push_back(steer_command(in_data));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (cmd_queue.size() == 0) begin
          $error("result with nothing expected: speed %0d turn_rate %0d",
                 out_data.speed, out_data.turn_rate);
          errs++;
        end else begin
          exp_cmd = cmd_queue.pop_front();
          if (out_data.speed !== exp_cmd.speed) begin
            $error("speed: expected %0d, got %0d", exp_cmd.speed, out_data.speed);
            errs++;
          end
          if (out_data.turn_rate !== exp_cmd.turn_rate) begin
            $error("turn_rate: expected %0d, got %0d", exp_cmd.turn_rate,
                   out_data.turn_rate);
            errs++;
          end
          if (out_data.at_waypoint !== exp_cmd.at_waypoint) begin
            $error("at_waypoint: expected %0d, got %0d", exp_cmd.at_waypoint,
                   out_data.at_waypoint);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
      pending <= cmd_queue.size();
    end
  end
endmodule

### tb/waypoint_steering_controller_test.sv
`timescale 1ns / 1ps
// Top of the steering controller testbench. It makes the clock and the one reset,
// feeds poses into the block and takes commands out of it, each side pausing at
// random, and writes the registers between phases while the block is idle. All
// prediction and comparison happens in the checker; this module gives the verdict.
module waypoint_steering_controller_test;
  import wsc_pkg::*;

  // Cycles without any item moving before the run is declared hung. This is ample
  // against the longest item and the receiver's long hold-off.
  localparam int HANG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 830;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  wsc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wsc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  int mismatches, pending, results_seen;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit sender_busy_mode = 1'b0;

  always #2 clk = ~clk;

  waypoint_steering_controller DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  waypoint_steering_controller_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen)
  );

  // Watchdog: any accepted item or result, register write or reset clears the count of idle cycles.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. It lowers ready for a random pause before each item, except in
  // stretches where it keeps ready high throughout. Once, after the first hundred
  // results, it holds off for a long while so that the block backs up and the
  // sender is left waiting on in_ready.
  initial begin : receiver
    int got;
    int gap;
    bit eager;
    got = 0;
    eager = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (got % 40 == 0) eager = ($urandom_range(0, 3) == 0);
      gap = eager ? 0 : $urandom_range(0, 11);
      if (got == 100) gap = 400;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  // Sends one item; valid is only lowered when a pause actually follows, so it is
  // never dropped and raised again within one time step.
  task automatic offer_pose(input wsc_in_t pose);
    int gap;
    gap = sender_busy_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pose;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Writes all eight registers on consecutive edges. Only called when idle.
  task automatic load_registers(input logic [15:0] vals [8]);
    in_valid <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Waits for every outstanding command; one result follows every item, so a short
  // margin afterwards is enough before touching the registers. The first edge lets
  // the checker count an item accepted at the edge just gone.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic wsc_in_t make_pose(input logic signed [23:0] px,
                                        input logic signed [23:0] py,
                                        input logic [15:0] hd,
                                        input logic signed [23:0] tx,
                                        input logic signed [23:0] ty,
                                        input bit obs, input bit fresh);
    wsc_in_t p;
    p.pos_x = px; p.pos_y = py; p.heading = hd;
    p.target_x = tx; p.target_y = ty;
    p.obstructed = obs; p.new_target = fresh;
    return p;
  endfunction

  // Mostly a vehicle near a nearby waypoint, with a random heading; the rest
  // are wild poses over the whole field range.
  function automatic wsc_in_t random_pose();
    wsc_in_t p;
    int reach;
    p.pos_x = 24'($urandom);
    p.pos_y = 24'($urandom);
    p.heading = 16'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      p.target_x = 24'($urandom);
      p.target_y = 24'($urandom);
    end else begin
      reach = ($urandom_range(0, 3) == 0) ? 60000 : 2500;
      p.target_x = 24'(p.pos_x + $signed($urandom_range(0, 2 * reach)) - reach);
      p.target_y = 24'(p.pos_y + $signed($urandom_range(0, 2 * reach)) - reach);
    end
    p.obstructed = ($urandom_range(0, 6) == 0);
    p.new_target = ($urandom_range(0, 9) == 0);
    return p;
  endfunction

  initial begin : stimulus
    logic [15:0] regs [8];
    wsc_in_t pose;
    int fails;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed poses under the reset settings.
    offer_pose(make_pose(24'sd0, 24'sd0, 16'd0, 24'sd0, 24'sd0, 1'b0, 1'b1));
    offer_pose(make_pose(24'sd100, -24'sd50, 16'hFFFF, 24'sd100, -24'sd50, 1'b1, 1'b0));
    offer_pose(make_pose(24'h7FFFFF, 24'h7FFFFF, 16'd0, 24'h800000, 24'h800000,
                         1'b0, 1'b1));
    offer_pose(make_pose(24'h800000, 24'h800000, 16'h8000, 24'h7FFFFF, 24'h7FFFFF,
                         1'b0, 1'b0));
    offer_pose(make_pose(24'h800000, 24'h7FFFFF, 16'h4000, 24'h7FFFFF, 24'h800000,
                         1'b1, 1'b0));
    // Waypoint straight behind on the x axis, heading zero: a half-turn error.
    offer_pose(make_pose(24'sd1000, 24'sd0, 16'd0, -24'sd1000, 24'sd0, 1'b0, 1'b1));
    offer_pose(make_pose(24'sd0, 24'sd0, 16'h8000, 24'sd5000, 24'sd0, 1'b0, 1'b1));
    // Obstructed with a positive error, then with a negative one.
    offer_pose(make_pose(24'sd0, 24'sd0, 16'd0, 24'sd0, 24'sd3000, 1'b1, 1'b1));
    offer_pose(make_pose(24'sd0, 24'sd0, 16'd0, 24'sd0, -24'sd3000, 1'b1, 1'b0));
    // Distances around the arrival and slow-down thresholds, on the bearing.
    offer_pose(make_pose(24'sd0, 24'sd0, 16'd0, 24'sd199, 24'sd0, 1'b0, 1'b1));
    offer_pose(make_pose(24'sd0, 24'sd0, 16'd0, 24'sd200, 24'sd0, 1'b0, 1'b0));
    offer_pose(make_pose(24'sd0, 24'sd0, 16'd0, 24'sd250, 24'sd0, 1'b0, 1'b0));
    offer_pose(make_pose(24'sd0, 24'sd0, 16'd0, 24'sd500, 24'sd0, 1'b0, 1'b0));
    offer_pose(make_pose(24'sd0, 24'sd0, 16'd0, 24'sd799, 24'sd0, 1'b0, 1'b0));
    offer_pose(make_pose(24'sd0, 24'sd0, 16'd0, 24'sd900, 24'sd0, 1'b0, 1'b0));
    // Large error built up over several items, then cleared by a new target.
    for (int i = 0; i < 4; i++)
      offer_pose(make_pose(24'sd0, 24'sd0, 16'hC000, 24'sd2000, 24'sd10, 1'b0, 1'b0));
    offer_pose(make_pose(24'sd0, 24'sd0, 16'hC000, 24'sd2000, 24'sd10, 1'b0, 1'b1));
    offer_pose(make_pose(24'sd0, 24'sd0, 16'h0300, -24'sd20, 24'sd4000, 1'b0, 1'b0));

    // Random phases, each under its own register settings, the extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: regs = '{16'd256, 16'd500, 16'd512, 16'd2048, 16'd200, 16'd800,
                    16'd1037, 16'd8192};
        1: regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF};
        2: regs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        // Slow zone no larger than the arrival zone.
        3: regs = '{16'd700, 16'd3000, 16'd4000, 16'd20000, 16'd1500, 16'd900,
                    16'd200, 16'd3000};
        default: foreach (regs[i]) regs[i] = 16'($urandom);
      endcase
      load_registers(regs);
      for (int k = 0; k < RANDOM_ITEMS / 6; k++) begin
        if (k % 30 == 0) sender_busy_mode = ($urandom_range(0, 3) == 0);
        pose = random_pose();
        offer_pose(pose);
      end
    end

    drain();
    repeat (50) @(posedge clk);

    fails = mismatches + ((pending != 0) ? 1 : 0);
    $display("Sent %0d poses over six register settings, %0d commands checked.",
             items_sent, results_seen);
    $display("Covered zero and half-turn vectors, obstruction, slow and arrive zones.");
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
design/wsc_pkg.sv
design/waypoint_steering_controller.sv
tb/waypoint_steering_controller_checker.sv
tb/waypoint_steering_controller_test.sv
